[rtl/tsiq_pkg.sv]
// shared types and constants for the target switch input qualifier
package tsiq_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;
   localparam int STICK_W     = 15;
   localparam int PAUSE_W     = 16;
   localparam int THRESH_W    = 23;
   localparam int SUM_W       = 24;
   localparam int TIME_W      = 32;

   localparam logic [STICK_W-1:0]  ENGAGE_RESET  = 15'd8192;
   localparam logic [STICK_W-1:0]  RELEASE_RESET = 15'd4096;
   localparam logic [PAUSE_W-1:0]  PAUSE_RESET   = 16'd150;
   localparam logic [PAUSE_W-1:0]  WINDOW_RESET  = 16'd250;
   localparam logic [THRESH_W-1:0] THRESH_RESET  = 23'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STICK_ENGAGE  = 3'd0,
      CSR_STICK_RELEASE = 3'd1,
      CSR_REARM_PAUSE   = 3'd2,
      CSR_WINDOW        = 3'd3,
      CSR_MOUSE_THRESH  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_STICK   = 2'd0,
      KIND_MOUSE   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_TOGGLE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      LATCH_NEUTRAL = 2'd0,
      LATCH_RIGHT   = 2'd1,
      LATCH_LEFT    = 2'd2
   } latch_type;

   // per-item control shared by the stick and mouse paths
   typedef struct packed {
      logic fire;     // item leaves the input register this cycle
      logic clear;    // lock lost or lock toggle
      logic stick;    // stick sample
      logic release_; // stick released
      logic mouse;    // mouse delta
   } step_type;

   typedef struct packed {
      logic fire;
      logic left;
   } request_type;

endpackage

[rtl/tsiq_stick.sv]
// stick hysteresis latch: state register and next-state logic
module tsiq_stick import tsiq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  logic signed [15:0] stick_x,
   input  logic [STICK_W-1:0] engage,
   input  logic [STICK_W-1:0] release_th,
   output latch_type          latch_next,
   output request_type        request
);

   latch_type latch_ff, latch_in;
   logic signed [17:0] x_ext, eng_pos, eng_neg;
   logic [16:0] x_mag;
   logic [STICK_W-1:0] rel_eff;
   latch_type stick_latch;
   request_type stick_req;

   always_comb begin
      x_ext   = 18'(stick_x);
      x_mag   = stick_x[15] ? 17'(-x_ext) : 17'(x_ext);
      eng_pos = $signed({3'b000, engage});
      eng_neg = -eng_pos;
      rel_eff = (release_th < engage) ? release_th : engage;

      stick_latch = latch_ff;
      stick_req   = '0;
      case (latch_ff)
         LATCH_RIGHT, LATCH_LEFT: begin
            if (x_mag <= 17'(rel_eff)) begin
               stick_latch = LATCH_NEUTRAL;
            end else if (latch_ff == LATCH_RIGHT && x_ext <= eng_neg) begin
               stick_latch = LATCH_LEFT;
               stick_req   = '{fire: 1'b1, left: 1'b1};
            end else if (latch_ff == LATCH_LEFT && x_ext >= eng_pos) begin
               stick_latch = LATCH_RIGHT;
               stick_req   = '{fire: 1'b1, left: 1'b0};
            end
         end
         default: begin
            stick_latch = LATCH_NEUTRAL;
            if (x_ext >= eng_pos) begin
               stick_latch = LATCH_RIGHT;
               stick_req   = '{fire: 1'b1, left: 1'b0};
            end else if (x_ext <= eng_neg) begin
               stick_latch = LATCH_LEFT;
               stick_req   = '{fire: 1'b1, left: 1'b1};
            end
         end
      endcase

      latch_next = latch_ff;
      request    = '0;
      if (step.clear || step.release_) begin
         latch_next = LATCH_NEUTRAL;
      end else if (step.stick) begin
         latch_next = stick_latch;
         request    = stick_req;
      end
      latch_in = step.fire ? latch_next : latch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= LATCH_NEUTRAL;
      end else begin
         latch_ff <= latch_in;
      end
   end

endmodule

[rtl/tsiq_mouse.sv]
// mouse accumulator with window, pause rearm and post-switch lock
module tsiq_mouse import tsiq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  step_type            step,
   input  logic signed [15:0]  mouse_dx,
   input  logic [TIME_W-1:0]   time_ms,
   input  logic [PAUSE_W-1:0]  rearm_pause,
   input  logic [PAUSE_W-1:0]  window,
   input  logic [THRESH_W-1:0] threshold,
   output request_type         request
);

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [TIME_W-1:0] start_ff, start_in, last_ff, last_in;
   logic open_ff, open_in, seen_ff, seen_in, armed_ff, armed_in;

   logic [TIME_W-1:0] gap, age;
   logic paused, armed_eff, expired, hit, active;
   logic signed [SUM_W-1:0] sum_base, sum_sat;
   logic signed [SUM_W:0] sum_wide;
   logic [SUM_W-1:0] sum_mag;

   always_comb begin
      gap       = time_ms - last_ff;
      age       = time_ms - start_ff;
      paused    = !seen_ff || (gap >= TIME_W'(rearm_pause));
      armed_eff = armed_ff || paused;
      expired   = !open_ff || paused || (age > TIME_W'(window));
      sum_base  = expired ? '0 : sum_ff;
      sum_wide  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(mouse_dx);
      // saturate to the 24-bit accumulator range
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      sum_mag = sum_sat[SUM_W-1] ? SUM_W'(-sum_sat) : SUM_W'(sum_sat);
      hit     = armed_eff && (threshold != '0) && (sum_mag >= SUM_W'(threshold));
      active  = step.mouse && (mouse_dx != '0);

      sum_in   = sum_ff;
      start_in = start_ff;
      last_in  = last_ff;
      open_in  = open_ff;
      seen_in  = seen_ff;
      armed_in = armed_ff;
      request  = '0;

      if (step.clear) begin
         sum_in   = '0;
         start_in = '0;
         last_in  = '0;
         open_in  = 1'b0;
         seen_in  = 1'b0;
         armed_in = 1'b1;
      end else if (active) begin
         last_in  = time_ms;
         seen_in  = 1'b1;
         start_in = expired ? time_ms : start_ff;
         open_in  = 1'b1;
         if (!armed_eff) begin
            sum_in   = '0;
            armed_in = 1'b0;
         end else if (hit) begin
            sum_in   = '0;
            start_in = '0;
            open_in  = 1'b0;
            armed_in = 1'b0;
            request  = '{fire: 1'b1, left: sum_sat[SUM_W-1]};
         end else begin
            sum_in   = sum_sat;
            armed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         start_ff <= '0;
         last_ff  <= '0;
         open_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         armed_ff <= 1'b1;
      end else if (step.fire) begin
         sum_ff   <= sum_in;
         start_ff <= start_in;
         last_ff  <= last_in;
         open_ff  <= open_in;
         seen_ff  <= seen_in;
         armed_ff <= armed_in;
      end
   end

endmodule

[rtl/target_switch_input_qualifier.sv]
// top level: input register, stick and mouse paths, result register, config registers
//
// Turns look input into target-switch requests while a hard lock is held.
// req_ channel: one input item per handshake; req_tuser carries the kind,
// req_tdata the locked flag, stick axis, mouse delta and timestamp.
// rsp_ channel: exactly one result item per input item, in order.
// csr_ channel: register writes, always ready; write only while idle.
// rsp_tvalid rises once the item has passed the input register and then the
// result register: the item sits in the input register, where the stick latch
// and mouse accumulator logic evaluate it against their state, then moves into
// the result register. Throughput is one item per cycle while the receiver
// does not stall; the state update of one item feeds the next item directly,
// so items may follow back to back.
// When the receiver stalls, the result register holds its item, the input
// register still takes one more item, and req_tready falls after that.
// Synchronous reset clears all state, restores register defaults and
// empties both pipeline registers.
module target_switch_input_qualifier import tsiq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [71:0]            req_tdata,  // locked, stick_x, mouse_dx, time_ms, zero pad
   input  logic [1:0]             req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // switch_request, switch_left, latch_now, zero pad
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [STICK_W-1:0]  engage_ff, release_ff;
   logic [PAUSE_W-1:0]  pause_ff, window_ff;
   logic [THRESH_W-1:0] thresh_ff;

   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic               s1_locked_ff;
   logic signed [15:0] s1_stick_ff, s1_dx_ff;
   logic [TIME_W-1:0]  s1_time_ff;

   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_data_ff;

   logic        advance;
   step_type    step;
   latch_type   latch_next;
   request_type stick_req, mouse_req;
   logic        any_req, any_left;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         engage_ff  <= ENGAGE_RESET;
         release_ff <= RELEASE_RESET;
         pause_ff   <= PAUSE_RESET;
         window_ff  <= WINDOW_RESET;
         thresh_ff  <= THRESH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STICK_ENGAGE:  engage_ff  <= csr_wdata[STICK_W-1:0];
            CSR_STICK_RELEASE: release_ff <= csr_wdata[STICK_W-1:0];
            CSR_REARM_PAUSE:   pause_ff   <= csr_wdata[PAUSE_W-1:0];
            CSR_WINDOW:        window_ff  <= csr_wdata[PAUSE_W-1:0];
            CSR_MOUSE_THRESH:  thresh_ff  <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff   <= kind_type'(req_tuser);
         s1_locked_ff <= req_tdata[0];
         s1_stick_ff  <= req_tdata[16:1];
         s1_dx_ff     <= req_tdata[32:17];
         s1_time_ff   <= req_tdata[64:33];
      end
   end

   always_comb begin
      step.fire     = advance;
      step.clear    = !s1_locked_ff || (s1_kind_ff == KIND_TOGGLE);
      step.stick    = s1_locked_ff && (s1_kind_ff == KIND_STICK);
      step.release_ = s1_locked_ff && (s1_kind_ff == KIND_RELEASE);
      step.mouse    = s1_locked_ff && (s1_kind_ff == KIND_MOUSE);
   end

   tsiq_stick u_stick (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stick_x    (s1_stick_ff),
      .engage     (engage_ff),
      .release_th (release_ff),
      .latch_next (latch_next),
      .request    (stick_req)
   );

   tsiq_mouse u_mouse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .mouse_dx    (s1_dx_ff),
      .time_ms     (s1_time_ff),
      .rearm_pause (pause_ff),
      .window      (window_ff),
      .threshold   (thresh_ff),
      .request     (mouse_req)
   );

   // only one path can be active for a given kind
   assign any_req  = stick_req.fire || mouse_req.fire;
   assign any_left = (stick_req.fire && stick_req.left) || (mouse_req.fire && mouse_req.left);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {latch_next, any_left, any_req};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_data_ff};

   a_left_needs_request : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && !rsp_tdata[0]))
      else $error("direction flagged without a request");

   a_latch_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:2] != 2'b11))
      else $error("latch code out of range");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_time_ff))
      else $error("input register lost an item while stalled");

   a_unlocked_quiet : assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_locked_ff) |=> !rsp_tdata[0] && (rsp_tdata[3:2] == LATCH_NEUTRAL))
      else $error("request raised without lock");

endmodule

[bench/switch_request_checker.sv]
// checker for the target switch input qualifier: predicts each result and compares it
module switch_request_checker import tsiq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [71:0]            req_tdata,  // locked, stick_x, mouse_dx, time_ms, zero pad
   input  logic [1:0]             req_tuser,  // kind
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,  // switch_request, switch_left, latch_now, zero pad
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_MAX = 8388607;
   localparam int SUM_MIN = -8388608;

   typedef struct packed {
      logic      request;
      logic      left;
      latch_type latch;
   } switch_result_type;

   // register copies
   logic [STICK_W-1:0]  engage_cfg;
   logic [STICK_W-1:0]  release_cfg;
   logic [PAUSE_W-1:0]  pause_cfg;
   logic [PAUSE_W-1:0]  window_cfg;
   logic [THRESH_W-1:0] thresh_cfg;

   // qualifier state
   latch_type         latch_st;
   int                accum;
   logic [TIME_W-1:0] win_start;
   logic              win_open;
   logic [TIME_W-1:0] last_time;
   logic              seen;
   logic              armed;

   switch_result_type pending_switches[$];
   int                errors = 0;

   assign failures = errors;

   function automatic void clear_state();
      latch_st  = LATCH_NEUTRAL;
      accum     = 0;
      win_start = '0;
      win_open  = 1'b0;
      last_time = '0;
      seen      = 1'b0;
      armed     = 1'b1;
   endfunction

   function automatic switch_result_type qualify_item(
      input kind_type          kind,
      input logic              locked,
      input logic signed [15:0] stick,
      input logic signed [15:0] delta,
      input logic [TIME_W-1:0] now
   );
      switch_result_type res;
      int                eng;
      int                rel;
      int                x;
      int                mag;
      int                sum;
      logic              paused;
      logic              expired;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] span;
      res = '{request: 1'b0, left: 1'b0, latch: LATCH_NEUTRAL};
      if (!locked || kind == KIND_TOGGLE) begin
         clear_state();
      end else if (kind == KIND_STICK) begin
         eng = int'(engage_cfg);
         // release never sits above engage
         rel = (release_cfg < engage_cfg) ? int'(release_cfg) : eng;
         x = int'(stick);
         mag = (x < 0) ? -x : x;
         if (latch_st != LATCH_NEUTRAL) begin
            if (mag <= rel) begin
               latch_st = LATCH_NEUTRAL;
            end else if (latch_st == LATCH_RIGHT && x <= -eng) begin
               latch_st = LATCH_LEFT;
               res.request = 1'b1;
               res.left = 1'b1;
            end else if (latch_st == LATCH_LEFT && x >= eng) begin
               latch_st = LATCH_RIGHT;
               res.request = 1'b1;
            end
         end else if (x >= eng) begin
            latch_st = LATCH_RIGHT;
            res.request = 1'b1;
         end else if (x <= -eng) begin
            latch_st = LATCH_LEFT;
            res.request = 1'b1;
            res.left = 1'b1;
         end
      end else if (kind == KIND_MOUSE) begin
         if (delta != 0) begin
            gap = now - last_time;
            paused = !seen || gap >= pause_cfg;
            if (!armed && paused)
               armed = 1'b1;
            span = now - win_start;
            expired = !win_open || paused || span > window_cfg;
            if (expired) begin
               accum = 0;
               win_start = now;
               win_open = 1'b1;
            end
            last_time = now;
            seen = 1'b1;
            if (!armed) begin
               accum = 0;
            end else begin
               sum = accum + int'(delta);
               if (sum > SUM_MAX) sum = SUM_MAX;
               if (sum < SUM_MIN) sum = SUM_MIN;
               accum = sum;
               mag = (sum < 0) ? -sum : sum;
               if (thresh_cfg != 0 && mag >= int'(thresh_cfg)) begin
                  res.request = 1'b1;
                  res.left = (sum < 0);
                  // fire disarms until the next pause or clear
                  accum = 0;
                  win_start = '0;
                  win_open = 1'b0;
                  armed = 1'b0;
               end
            end
         end
      end else begin
         latch_st = LATCH_NEUTRAL;
      end
      res.latch = latch_st;
      return res;
   endfunction

   function automatic logic field_ok(input string name, input int want, input int got);
      if (want != got)
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      return want == got;
   endfunction

   always @(posedge clock) begin
      switch_result_type want;
      logic              good;
      if (reset) begin
         engage_cfg  = ENGAGE_RESET;
         release_cfg = RELEASE_RESET;
         pause_cfg   = PAUSE_RESET;
         window_cfg  = WINDOW_RESET;
         thresh_cfg  = THRESH_RESET;
         clear_state();
         pending_switches.delete();
      end else begin
         // results leave through the input and result registers after their item, so check before queueing
         if (rsp_tvalid && rsp_tready) begin
            if (pending_switches.size() == 0) begin
               $display("%0t: result with none expected, actual %0h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_switches.pop_front();
               good = field_ok("switch_request", want.request, rsp_tdata[0]);
               good = field_ok("switch_left", want.left, rsp_tdata[1]) && good;
               good = field_ok("latch_now", int'(want.latch), rsp_tdata[3:2]) && good;
               if (!good)
                  errors++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STICK_ENGAGE:  engage_cfg  = csr_wdata[STICK_W-1:0];
               CSR_STICK_RELEASE: release_cfg = csr_wdata[STICK_W-1:0];
               CSR_REARM_PAUSE:   pause_cfg   = csr_wdata[PAUSE_W-1:0];
               CSR_WINDOW:        window_cfg  = csr_wdata[PAUSE_W-1:0];
               CSR_MOUSE_THRESH:  thresh_cfg  = csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_switches.push_back(qualify_item(kind_type'(req_tuser), req_tdata[0],
               req_tdata[16:1], req_tdata[32:17], req_tdata[64:33]));
      end
      outstanding <= pending_switches.size();
   end

endmodule

[bench/target_switch_input_qualifier_test.sv]
// testbench top: clock, reset, stimulus and verdict for the target switch input qualifier
module target_switch_input_qualifier_test;
   import tsiq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_LEN    = 80;
   localparam int CALM_FROM   = 900;
   localparam int CALM_TO     = 1100;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [71:0]            req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   failures;
   int   outstanding;
   int   sent = 0;
   int   cycles = 0;
   int   hold_left = 0;
   bit   held_once = 1'b0;
   logic calm;

   // stimulus view of the current settings
   int   engage_set = 8192;
   int   release_set = 4096;
   int   mouse_dir = 1;
   logic [31:0] ms = '0;

   assign calm = sent >= CALM_FROM && sent < CALM_TO;

   target_switch_input_qualifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   switch_request_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up
   always @(posedge clock) begin
      if (!held_once && sent >= HOLD_AT) begin
         held_once <= 1'b1;
         hold_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 21);
      end
   end

   task automatic send_item(input kind_type kind, input logic locked, input logic [15:0] sx,
                            input logic [15:0] mdx, input logic [31:0] stamp);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, stamp, mdx, sx, locked};
      do @(posedge clock); while (!req_tready);
      sent <= sent + 1;
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input int engage, input int rel, input int pause,
                               input int window, input int thresh);
      wait_results();
      write_reg(CSR_STICK_ENGAGE, engage);
      write_reg(CSR_STICK_RELEASE, rel);
      write_reg(CSR_REARM_PAUSE, pause);
      write_reg(CSR_WINDOW, window);
      write_reg(CSR_MOUSE_THRESH, thresh);
      csr_valid <= 1'b0;
      engage_set = engage;
      release_set = rel;
   endtask

   task automatic send_random(input bit heavy);
      kind_type    kind;
      logic        locked;
      logic [15:0] sx;
      logic [15:0] mdx;
      int          pick;
      int          mag;
      pick = $urandom_range(99);
      if (heavy)
         kind = (pick < 95) ? KIND_MOUSE : (pick < 98) ? KIND_STICK : KIND_RELEASE;
      else
         kind = (pick < 42) ? KIND_STICK : (pick < 86) ? KIND_MOUSE :
                (pick < 95) ? KIND_RELEASE : KIND_TOGGLE;
      locked = heavy ? 1'b1 : ($urandom_range(99) >= 3);

      // stick values cluster round the thresholds
      pick = $urandom_range(99);
      if (pick < 50) begin
         mag = ($urandom_range(1) ? engage_set : release_set) + int'($urandom_range(4)) - 2;
         if (mag < 0) mag = 0;
         sx = 16'($urandom_range(1) ? -mag : mag);
      end else if (pick < 80) begin
         sx = 16'(int'($urandom_range(32768)) - 16384);
      end else begin
         sx = 16'($urandom);
      end

      if ($urandom_range(99) < (heavy ? 1 : 10))
         mouse_dir = -mouse_dir;
      pick = $urandom_range(99);
      if (heavy)
         mdx = (pick < 90) ? 16'(mouse_dir * int'($urandom_range(32767, 30000))) : 16'($urandom);
      else if (pick < 5)
         mdx = '0;
      else if (pick < 55)
         mdx = 16'(mouse_dir * int'($urandom_range(600)));
      else if (pick < 75)
         mdx = 16'(int'($urandom_range(1200)) - 600);
      else
         mdx = 16'($urandom);

      pick = $urandom_range(99);
      if (heavy)
         ms = ms + ((pick < 98) ? $urandom_range(20) : $urandom_range(200000, 65535));
      else if (pick < 70)
         ms = ms + $urandom_range(60);
      else if (pick < 90)
         ms = ms + $urandom_range(400, 100);
      else if (pick < 97)
         ms = ms + $urandom_range(70000);
      else
         ms = $urandom;
      send_item(kind, locked, sx, mdx, ms);
   endtask

   task automatic run_phase(input int engage, input int rel, input int pause, input int window,
                            input int thresh, input int count, input bit heavy);
      program_regs(engage, rel, pause, window, thresh);
      repeat (count) send_random(heavy);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stick latch at the default thresholds
      send_item(KIND_STICK, 1'b1, 16'sd16384, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, -16'sd16384, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, 16'sd4096, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, 16'h8000, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, 16'sd16384, '0, 32'd0);
      send_item(KIND_RELEASE, 1'b1, 16'sd16384, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, 16'sd8191, '0, 32'd0);
      send_item(KIND_STICK, 1'b1, 16'h7fff, '0, 32'd0);
      send_item(KIND_STICK, 1'b0, 16'h7fff, 16'hffff, 32'hffff_ffff);
      send_item(KIND_STICK, 1'b1, 16'sd8192, '0, 32'd0);
      send_item(KIND_TOGGLE, 1'b1, 16'h7fff, 16'h7fff, 32'd50);
      // mouse with firing disabled
      send_item(KIND_MOUSE, 1'b1, '0, '0, 32'd100);
      send_item(KIND_MOUSE, 1'b1, '0, 16'h7fff, 32'd100);
      send_item(KIND_MOUSE, 1'b1, '0, 16'h8000, 32'd110);

      // mouse switching at a threshold of 1.0 in Q8.8
      program_regs(8192, 4096, 150, 250, 256);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd200, 32'd1000);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'd1010);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd500, 32'd1020);
      send_item(KIND_MOUSE, 1'b1, '0, -16'sd300, 32'd1200);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'd1210);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'd1470);
      // timestamps wrapping through zero
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'hffff_fff0);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'd5);
      send_item(KIND_MOUSE, 1'b1, '0, 16'sd100, 32'd60);

      run_phase(8192, 4096, 150, 250, 256, 180, 1'b0);
      run_phase(0, 0, 0, 0, 1, 150, 1'b0);
      // release above engage, window shorter than the rearm pause
      run_phase(4000, 16384, 400, 100, 600, 180, 1'b0);
      // accumulator saturation, with and without firing
      run_phase(16384, 16384, 65535, 65535, 0, 300, 1'b1);
      run_phase(12000, 2000, 65535, 65535, 8388607, 300, 1'b1);
      run_phase($urandom_range(16384), $urandom_range(16384), $urandom_range(500),
                $urandom_range(500), $urandom_range(2000, 1), 200, 1'b0);
      run_phase(8192, 4096, 150, 250, 800, 200, 1'b0);

      wait_results();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
